/* rtl/core/bicubic_bspline_surface_eval_macros.svh */
// Assertion macros shared by the surface evaluator RTL
`ifndef BICUBIC_BSPLINE_SURFACE_EVAL_MACROS_SVH
`define BICUBIC_BSPLINE_SURFACE_EVAL_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain check at every clock edge
`define BBSE_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
// Same-cycle implication
`define BBSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define BBSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define BBSE_ASSERT(lbl, clk, rstn, expr, msg)
`define BBSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BBSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/core/bbse_pkg.sv */
// Shared types, constants and helpers of the B-spline surface evaluator
`timescale 1ns / 1ps
`default_nettype none
package bbse_pkg;

  // Lattice geometry: 64 x 64 entries, row and column wrap by truncation
  localparam int LatticeBits = 6;
  localparam int LatticeSize = 1 << LatticeBits;

  // Field widths
  localparam int CoordFracBits = 16;
  localparam int CpuBits       = 6;
  localparam int ValueWidth    = 32;

  // Basis arithmetic: Q0.28 fractions, powers up to 1.0 need one more bit
  localparam int WFrac   = 28;
  localparam int PowW    = WFrac + 1;
  localparam int WeightW = 31;  // weights scaled by 6, below 6.0
  localparam int PairW   = 29;  // pair weight in Q0.28, up to 1.0
  localparam int QuotW   = 32;  // pair product over 2^30, before the divide by 9
  localparam int AccW    = 66;

  // Divide by 9 as a multiply by ceil(2^35 / 9), exact below 2^33
  localparam int RecipShift = 35;
  localparam logic [QuotW-1:0] Recip9 = 32'd3817748708;

  // Request commands
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  // Configuration register indexes
  localparam logic CfgCellsPerUnit = 1'b0;
  localparam logic CfgBaseOffset   = 1'b1;

  typedef logic [WeightW-1:0]          weight_t;
  typedef weight_t [3:0]               basis_t;
  typedef logic [LatticeBits-1:0]      idx_t;
  typedef logic signed [ValueWidth-1:0] value_t;

  // Control from the sequencer to the multiply-accumulate pipeline
  typedef struct packed {
    logic clear;
    logic tap;
    logic last;
  } mac_ctrl_t;

  // Q0.28 product rounded half up
  function automatic logic [PowW-1:0] rnd_mul(input logic [PowW-1:0] a,
                                              input logic [PowW-1:0] b);
    logic [2*PowW-1:0] p;
    p = a * b;
    p = p + ((2*PowW)'(1) << (WFrac - 1));
    return p[WFrac +: PowW];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/bicubic_bspline_surface_eval.sv */
// Top level of the bicubic uniform B-spline surface evaluator
// A write request leaves the block idle, so the next request can be taken in the following cycle.
// An evaluate request passes through the basis units, then makes 16 lattice reads on the single
// read port, then is accumulated, rounded, offset and saturated. No request is taken until its
// result is loaded into the output register, which waits while an earlier result is stalled.
// Reset clears control state and sets cells_per_unit to 1 and base_offset to 0;
// lattice contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "bicubic_bspline_surface_eval_macros.svh"
module bicubic_bspline_surface_eval (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [bbse_pkg::LatticeBits-1:0]      lattice_row_i,
  input  logic [bbse_pkg::LatticeBits-1:0]      lattice_col_i,
  input  logic signed [bbse_pkg::ValueWidth-1:0] control_value_i,
  input  logic [bbse_pkg::CoordFracBits-1:0]    x_coord_i,
  input  logic [bbse_pkg::CoordFracBits-1:0]    y_coord_i,
  input  logic                                  end_of_grid_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bbse_pkg::ValueWidth-1:0] surface_value_o,
  output logic                                  grid_done_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  cfg_index_i,
  input  logic [bbse_pkg::ValueWidth-1:0]       cfg_data_i
);
  import bbse_pkg::*;

  localparam int ScaleW = CoordFracBits + CpuBits;
  localparam int TapW   = 4;
  localparam logic [TapW-1:0] LastTap = '1;

  typedef enum logic [2:0] {ST_IDLE, ST_BASIS, ST_TAPS, ST_DRAIN, ST_OUT} state_e;

  state_e          state_q;
  logic [TapW-1:0] tap_q;
  logic            out_valid_q, grid_done_q;
  value_t          surface_q;

  logic [CpuBits-1:0] cpu_q;
  value_t             offset_q;

  idx_t cell_x_q, cell_y_q;
  logic grid_q;

  logic              accept, acc_write, acc_eval, out_free, out_load;
  logic [ScaleW-1:0] xs, ys;
  logic              x_done, y_done, mac_valid, lat_we, lat_re;
  basis_t            wx_all, wy_all;
  value_t            lat_rdata, mac_res;
  mac_ctrl_t         mac_ctrl;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q    <= CpuBits'(1);
      offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCellsPerUnit: cpu_q    <= cfg_data_i[CpuBits-1:0];
        CfgBaseOffset:   offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_write  = accept && (command_i == CmdWrite);
  assign acc_eval   = accept && (command_i == CmdEval);

  // Scale the point by the lattice density: cell above, fraction below
  assign xs = x_coord_i * cpu_q;
  assign ys = y_coord_i * cpu_q;

  always_ff @(posedge clk_i) begin
    if (acc_eval) begin
      cell_x_q <= xs[ScaleW-1:CoordFracBits];
      cell_y_q <= ys[ScaleW-1:CoordFracBits];
      grid_q   <= end_of_grid_i;
    end
  end

  // Basis weights for each axis
  bbse_basis u_basis_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (acc_eval),
    .frac_i    (xs[CoordFracBits-1:0]),
    .done_o    (x_done),
    .weights_o (wx_all)
  );

  bbse_basis u_basis_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (acc_eval),
    .frac_i    (ys[CoordFracBits-1:0]),
    .done_o    (y_done),
    .weights_o (wy_all)
  );

  // Lattice: writes only while idle, reads only while stepping taps
  assign lat_we = acc_write;
  assign lat_re = (state_q == ST_TAPS);

  bbse_lattice u_lattice (
    .clk_i      (clk_i),
    .we_i       (lat_we),
    .wrow_i     (lattice_row_i),
    .wcol_i     (lattice_col_i),
    .wdata_i    (control_value_i),
    .re_i       (lat_re),
    .cell_row_i (cell_y_q),
    .cell_col_i (cell_x_q),
    .off_row_i  (tap_q[3:2]),
    .off_col_i  (tap_q[1:0]),
    .rdata_o    (lat_rdata)
  );

  // Tap sequencing into the accumulate pipeline
  assign mac_ctrl.clear = (state_q == ST_BASIS) && x_done;
  assign mac_ctrl.tap   = (state_q == ST_TAPS);
  assign mac_ctrl.last  = (tap_q == LastTap);

  bbse_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .wx_i        (wx_all[tap_q[1:0]]),
    .wy_i        (wy_all[tap_q[3:2]]),
    .value_i     (lat_rdata),
    .offset_i    (offset_q),
    .res_valid_o (mac_valid),
    .res_o       (mac_res)
  );

  // Output register loads a ready result when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (((state_q == ST_DRAIN) && mac_valid) || (state_q == ST_OUT)) && out_free;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
      surface_q   <= '0;
      grid_done_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        surface_q   <= mac_res;
        grid_done_q <= grid_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (acc_eval) state_q <= ST_BASIS;
        ST_BASIS: if (x_done) begin
          state_q <= ST_TAPS;
          tap_q   <= '0;
        end
        ST_TAPS: begin
          tap_q <= tap_q + 1'b1;
          if (tap_q == LastTap) state_q <= ST_DRAIN;
        end
        ST_DRAIN: if (mac_valid) begin
          state_q <= out_free ? ST_IDLE : ST_OUT;
        end
        ST_OUT: if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign surface_value_o = surface_q;
  assign grid_done_o     = grid_done_q;

  // Checks
  `BBSE_ASSERT(a_basis_sync, clk_i, rst_ni, x_done == y_done, "basis units out of step")
  `BBSE_ASSERT(a_no_rw_clash, clk_i, rst_ni, !(lat_we && lat_re), "lattice read during write")
  `BBSE_ASSERT_IMPL(a_res_in_drain, clk_i, rst_ni, mac_valid, state_q == ST_DRAIN, "result outside drain")
  `BBSE_ASSERT_IMPL(a_out_from_result, clk_i, rst_ni, $rose(out_valid_o), ($past(state_q) == ST_DRAIN) || ($past(state_q) == ST_OUT), "output without result")
  `BBSE_ASSERT_NEXT(a_taps_end, clk_i, rst_ni, (state_q == ST_TAPS) && (tap_q == LastTap), state_q == ST_DRAIN, "tap count overrun")

endmodule
`default_nettype wire

/* rtl/core/bbse_basis.sv */
// Iterative cubic B-spline basis unit: four weights from one fraction
`timescale 1ns / 1ps
`default_nettype none
module bbse_basis (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [bbse_pkg::CoordFracBits-1:0]   frac_i,
  output logic                                 done_o,
  output bbse_pkg::basis_t                     weights_o
);
  import bbse_pkg::*;

  localparam int CalcW = 34;
  localparam logic [PowW-1:0] One = {1'b1, {WFrac{1'b0}}};
  localparam logic signed [CalcW-1:0] FourOne = CalcW'(64'd4 << WFrac);
  localparam logic signed [CalcW-1:0] SixOne  = CalcW'(64'd6 << WFrac);

  typedef enum logic [2:0] {B_IDLE, B_S2, B_S3, B_U2, B_U3, B_FIN} bstate_e;

  bstate_e state_q;
  logic    done_q;

  logic [PowW-1:0] s_q, u_q, s2_q, s3_q, u2_q, u3_q;
  logic [PowW-1:0] s_in, op_a, op_b, prod_r;
  basis_t          weights_q, weights_d;

  logic signed [CalcW-1:0] s2_x, s3_x, u3_x, b1_s, b2_s;

  // Sequencer: one rounded multiply per step, then the weight step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == B_FIN);
      unique case (state_q)
        B_IDLE: if (start_i) state_q <= B_S2;
        B_S2:   state_q <= B_S3;
        B_S3:   state_q <= B_U2;
        B_U2:   state_q <= B_U3;
        B_U3:   state_q <= B_FIN;
        B_FIN:  state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Shared multiplier operands
  always_comb begin
    op_a = s_q;
    op_b = s_q;
    unique case (state_q)
      B_S3: begin
        op_a = s2_q;
        op_b = s_q;
      end
      B_U2: begin
        op_a = u_q;
        op_b = u_q;
      end
      B_U3: begin
        op_a = u2_q;
        op_b = u_q;
      end
      default: ;
    endcase
  end

  assign prod_r = rnd_mul(op_a, op_b);
  assign s_in   = {1'b0, frac_i, {(WFrac - CoordFracBits){1'b0}}};

  // Weights scaled by 6; the second inner weight closes the partition of unity
  assign s2_x = CalcW'(s2_q);
  assign s3_x = CalcW'(s3_q);
  assign u3_x = CalcW'(u3_q);
  assign b1_s = 3 * s3_x - 6 * s2_x + FourOne;
  assign b2_s = SixOne - u3_x - b1_s - s3_x;

  always_comb begin
    weights_d[0] = WeightW'(u3_q);
    weights_d[1] = b1_s[CalcW-1] ? '0 : b1_s[WeightW-1:0];
    weights_d[2] = b2_s[CalcW-1] ? '0 : b2_s[WeightW-1:0];
    weights_d[3] = WeightW'(s3_q);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && start_i) begin
      s_q <= s_in;
      u_q <= One - s_in;
    end
    if (state_q == B_S2)  s2_q <= prod_r;
    if (state_q == B_S3)  s3_q <= prod_r;
    if (state_q == B_U2)  u2_q <= prod_r;
    if (state_q == B_U3)  u3_q <= prod_r;
    if (state_q == B_FIN) weights_q <= weights_d;
  end

  assign done_o    = done_q;
  assign weights_o = weights_q;

endmodule
`default_nettype wire

/* rtl/core/bbse_lattice.sv */
// Control lattice memory with wrapped neighborhood addressing
`timescale 1ns / 1ps
`default_nettype none
module bbse_lattice (
  input  logic              clk_i,
  input  logic              we_i,
  input  bbse_pkg::idx_t    wrow_i,
  input  bbse_pkg::idx_t    wcol_i,
  input  bbse_pkg::value_t  wdata_i,
  input  logic              re_i,
  input  bbse_pkg::idx_t    cell_row_i,
  input  bbse_pkg::idx_t    cell_col_i,
  input  logic [1:0]        off_row_i,
  input  logic [1:0]        off_col_i,
  output bbse_pkg::value_t  rdata_o
);
  import bbse_pkg::*;

  localparam int Depth = LatticeSize * LatticeSize;
  localparam int AddrW = 2 * LatticeBits;

  value_t           mem_q [Depth];
  value_t           rdata_q;
  idx_t             rrow, rcol;
  logic [AddrW-1:0] waddr, raddr;

  // Neighborhood indexes wrap around the lattice edge
  assign rrow  = cell_row_i + LatticeBits'(off_row_i);
  assign rcol  = cell_col_i + LatticeBits'(off_col_i);
  assign waddr = {wrow_i, wcol_i};
  assign raddr = {rrow, rcol};

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/bbse_mac.sv */
// Pair weight, multiply-accumulate, rounding, offset and saturation pipeline
`timescale 1ns / 1ps
`default_nettype none
module bbse_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bbse_pkg::mac_ctrl_t  ctrl_i,
  input  bbse_pkg::weight_t    wx_i,
  input  bbse_pkg::weight_t    wy_i,
  input  bbse_pkg::value_t     value_i,
  input  bbse_pkg::value_t     offset_i,
  output logic                 res_valid_o,
  output bbse_pkg::value_t     res_o
);
  import bbse_pkg::*;

  localparam int PairProdW = 2 * WeightW;
  localparam int QuotShift = PairProdW - QuotW;
  localparam int RecipW    = 2 * QuotW;
  localparam int MacW      = ValueWidth + PairW + 1;
  localparam int SumW      = AccW - WFrac + 1;
  localparam logic [PairProdW-1:0] PairHalf   = PairProdW'(64'd18 << WFrac);
  localparam logic signed [AccW-1:0] AccHalf  = AccW'(64'd1 << (WFrac - 1));

  // Control pipeline
  logic a_vld_q, a_last_q, b_vld_q, b_last_q, c_last_q, d_vld_q, res_vld_q;

  // Data pipeline
  logic [QuotW-1:0]       q_q;
  logic [PairW-1:0]       w_q;
  value_t                 v_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [SumW-1:0] sum_q;
  value_t                 res_q;

  logic [PairProdW-1:0]      pair_p, pair_r;
  logic [RecipW-1:0]         recip_p;
  logic signed [MacW-1:0]    mac_p;
  logic signed [AccW-1:0]    acc_rnd;
  logic signed [SumW-2:0]    rnd_val;
  logic signed [SumW-1:0]    sum_d;
  logic                      ovf;
  value_t                    sat_d;

  // Stage A: wx * wy + 18 * 2^28, scaled down by 2^30
  assign pair_p = wx_i * wy_i;
  assign pair_r = pair_p + PairHalf;

  // Stage B: divide by 9 through the reciprocal
  assign recip_p = q_q * Recip9;

  // Stage C: weighted lattice value into the accumulator
  assign mac_p = $signed({1'b0, w_q}) * v_q;

  // Stage D: round half up to the value LSB and add the offset
  assign acc_rnd = acc_q + AccHalf;
  assign rnd_val = $signed(acc_rnd[AccW-1:WFrac]);
  assign sum_d   = SumW'(rnd_val) + SumW'(offset_i);

  // Stage E: saturate to the value range
  assign ovf = !((&sum_q[SumW-1:ValueWidth-1]) || !(|sum_q[SumW-1:ValueWidth-1]));
  always_comb begin
    sat_d = sum_q[ValueWidth-1:0];
    if (ovf) sat_d = {sum_q[SumW-1], {(ValueWidth-1){!sum_q[SumW-1]}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      a_last_q  <= 1'b0;
      b_vld_q   <= 1'b0;
      b_last_q  <= 1'b0;
      c_last_q  <= 1'b0;
      d_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      a_vld_q   <= ctrl_i.tap;
      a_last_q  <= ctrl_i.tap & ctrl_i.last;
      b_vld_q   <= a_vld_q;
      b_last_q  <= a_last_q;
      c_last_q  <= b_last_q;
      d_vld_q   <= c_last_q;
      res_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= pair_r[QuotShift +: QuotW];
    w_q <= recip_p[RecipShift +: PairW];
    v_q <= value_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (b_vld_q) begin
      acc_q <= acc_q + AccW'(mac_p);
    end
    if (c_last_q) sum_q <= sum_d;
    if (d_vld_q)  res_q <= sat_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

/* test/bicubic_bspline_surface_eval_test.sv */
// Self-checking testbench of the bicubic B-spline surface evaluator
`timescale 1ns / 1ps
module bicubic_bspline_surface_eval_test;
  import bbse_pkg::*;

  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 32;
  localparam int HoldCycles   = 600;
  localparam int PhaseItems   = 194;
  localparam longint Q28One   = 64'sd1 << 28;
  localparam longint Q28Half  = 64'sd1 << 27;

  typedef enum logic [2:0] {
    RowWrite,
    RowEval,
    RowFill,
    RowCells,
    RowOffset
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    idx_t        row;
    idx_t        col;
    logic [31:0] value;
    logic [15:0] x;
    logic [15:0] y;
    logic        eog;
    bit          typed;
    logic [31:0] want;
  } stim_row_t;

  typedef struct {
    value_t height;
    logic   grid_done;
  } surface_result_t;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = CmdWrite;
  idx_t        lattice_row_i = '0;
  idx_t        lattice_col_i = '0;
  value_t      control_value_i = '0;
  logic [15:0] x_coord_i = '0;
  logic [15:0] y_coord_i = '0;
  logic        end_of_grid_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  value_t      surface_value_o;
  logic        grid_done_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgCellsPerUnit;
  logic [31:0] cfg_data_i = '0;

  // Shadow state of the block
  value_t      lattice_shadow [LatticeSize*LatticeSize];
  bit          lattice_written [LatticeSize*LatticeSize];
  logic [5:0]  density = 6'd1;
  value_t      height_offset = '0;

  surface_result_t awaited_results [$];
  int          mismatch_count = 0;
  int          sent_items = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asks = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          cycle_count = 0;

  // Directed requests: extremes, saturation, density corner cases
  stim_row_t directed_rows [22] = '{
    '{RowFill,   6'd0,  6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'h0000, 16'h0000, 1'b1, 1'b1, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 32'h0},
    '{RowWrite,  6'd0,  6'd0,  32'h7FFF_FFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowWrite,  6'd63, 6'd63, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'h0},
    '{RowWrite,  6'd1,  6'd2,  32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'h8000, 16'h4000, 1'b1, 1'b0, 32'h0},
    '{RowOffset, 6'd0,  6'd0,  32'h7FFF_FFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowFill,   6'd0,  6'd0,  32'h7FFF_FFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'h1234, 16'hFEDC, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{RowOffset, 6'd0,  6'd0,  32'h8000_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowFill,   6'd0,  6'd0,  32'h8000_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'hFFFF, 16'h0000, 1'b1, 1'b1, 32'h8000_0000},
    '{RowOffset, 6'd0,  6'd0,  32'h0001_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowFill,   6'd0,  6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'h0000, 16'hFFFF, 1'b0, 1'b1, 32'h0001_0000},
    '{RowCells,  6'd0,  6'd0,  32'd61,        16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'h0},
    '{RowCells,  6'd0,  6'd0,  32'd63,        16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'hFFFF, 16'h8000, 1'b0, 1'b0, 32'h0},
    '{RowCells,  6'd0,  6'd0,  32'd0,         16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0},
    '{RowEval,   6'd0,  6'd0,  32'h0,         16'h8000, 16'h8000, 1'b1, 1'b1, 32'h0001_0000}
  };

  bicubic_bspline_surface_eval u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .lattice_row_i  (lattice_row_i),
    .lattice_col_i  (lattice_col_i),
    .control_value_i(control_value_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .end_of_grid_i  (end_of_grid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .surface_value_o(surface_value_o),
    .grid_done_o    (grid_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted here once the stimulus asks for it
  always @(posedge clk_i) begin
    if (hold_asks != hold_served) begin
      hold_left <= HoldCycles;
      hold_served <= hold_served + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Result checker and receiver stall
  always @(posedge clk_i) begin
    surface_result_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", surface_value_o, '0);
      end else begin
        head = awaited_results.pop_front();
        if (surface_value_o !== head.height)
          report_mismatch("surface_value", surface_value_o, head.height);
        if (grid_done_o !== head.grid_done)
          report_mismatch("grid_done", 32'(grid_done_o), 32'(head.grid_done));
      end
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Q0.28 product, rounded half up
  function automatic longint q28_mul(input longint a, input longint b);
    return (a * b + Q28Half) >>> 28;
  endfunction

  // Cubic B-spline weights scaled by 6, in Q0.28
  function automatic void spline_weights(input logic [15:0] frac, output longint w [4]);
    longint s, u, s2, s3, u2, u3, b1, b2;
    s  = longint'(frac) <<< 12;
    u  = Q28One - s;
    s2 = q28_mul(s, s);
    s3 = q28_mul(s2, s);
    u2 = q28_mul(u, u);
    u3 = q28_mul(u2, u);
    b1 = 3 * s3 - 6 * s2 + 4 * Q28One;
    b2 = 6 * Q28One - u3 - b1 - s3;
    if (b1 < 0) b1 = 0;
    if (b2 < 0) b2 = 0;
    w[0] = u3;
    w[1] = b1;
    w[2] = b2;
    w[3] = s3;
  endfunction

  function automatic int cell_of(input logic [15:0] coord);
    return int'((longint'(coord) * longint'(density)) >>> 16);
  endfunction

  function automatic int lattice_index(input int cy, input int cx, input int l, input int k);
    return ((cy + l) % LatticeSize) * LatticeSize + ((cx + k) % LatticeSize);
  endfunction

  // Predicted height at (x, y) from the shadow lattice and settings
  function automatic value_t surface_height(input logic [15:0] x, input logic [15:0] y);
    longint xs, ys, w, total;
    longint wx [4];
    longint wy [4];
    logic signed [95:0] acc, wide_w, wide_v;
    xs = longint'(x) * longint'(density);
    ys = longint'(y) * longint'(density);
    spline_weights(16'(xs), wx);
    spline_weights(16'(ys), wy);
    acc = '0;
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 4; k++) begin
        w = (wx[k] * wy[l] + 18 * Q28One) / (36 * Q28One);
        wide_w = w;
        wide_v = lattice_shadow[lattice_index(cell_of(y), cell_of(x), l, k)];
        acc = acc + wide_w * wide_v;
      end
    end
    acc = (acc + (96'sd1 <<< 27)) >>> 28;
    total = signed'(acc[63:0]) + longint'(height_offset);
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return value_t'(total);
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return value_t'(int'($urandom_range(131072)) - 65536);
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one request, wait for it to be taken, then update the shadow state
  task automatic put_request(input logic cmd, input idx_t row, input idx_t col,
                             input value_t value, input logic [15:0] x,
                             input logic [15:0] y, input logic eog,
                             input bit typed, input value_t want);
    surface_result_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    lattice_row_i   <= row;
    lattice_col_i   <= col;
    control_value_i <= value;
    x_coord_i       <= x;
    y_coord_i       <= y;
    end_of_grid_i   <= eog;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    if (cmd == CmdWrite) begin
      lattice_shadow[{row, col}]  = value;
      lattice_written[{row, col}] = 1'b1;
    end else begin
      entry.height    = typed ? want : surface_height(x, y);
      entry.grid_done = eog;
      awaited_results = {awaited_results, entry};
    end
  endtask

  // Write the 4x4 neighborhood of (x, y): all of it, or only entries never written
  task automatic cover_neighborhood(input logic [15:0] x, input logic [15:0] y,
                                    input bit overwrite, input value_t fill);
    int idx;
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 4; k++) begin
        idx = lattice_index(cell_of(y), cell_of(x), l, k);
        if (overwrite || !lattice_written[idx])
          put_request(CmdWrite, idx_t'(idx / LatticeSize), idx_t'(idx % LatticeSize),
                      overwrite ? fill : pick_value(), pick_coord(), pick_coord(),
                      1'($urandom), 1'b0, '0);
      end
    end
  endtask

  task automatic eval_point(input logic [15:0] x, input logic [15:0] y, input logic eog,
                            input bit typed, input value_t want);
    cover_neighborhood(x, y, 1'b0, '0);
    put_request(CmdEval, idx_t'($urandom), idx_t'($urandom), value_t'($urandom),
                x, y, eog, typed, want);
  endtask

  // Sender pauses until every awaited result is back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Drained, plus time for a trailing write to finish
  task automatic wait_idle();
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_register(input logic index, input logic [31:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == CfgCellsPerUnit) density = data[5:0];
    else height_offset = data;
  endtask

  task automatic run_row(input stim_row_t r);
    case (r.kind)
      RowWrite:  put_request(CmdWrite, r.row, r.col, r.value, r.x, r.y, r.eog, 1'b0, '0);
      RowEval:   eval_point(r.x, r.y, r.eog, r.typed, r.want);
      RowFill:   cover_neighborhood(r.x, r.y, 1'b1, r.value);
      RowCells:  set_register(CfgCellsPerUnit, r.value);
      RowOffset: set_register(CfgBaseOffset, r.value);
      default:   ;
    endcase
  endtask

  initial begin
    int goal, phase_start;
    logic [5:0] cells;
    logic [31:0] offset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) run_row(directed_rows[i]);

    // Random phases; each idling mode is used twice with different settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin cells = 6'd1;  offset = 32'h0; end
        1: begin cells = 6'd61; offset = 32'h7FFF_FFFF; end
        2: begin cells = 6'd2;  offset = $urandom; end
        3: begin cells = 6'd63; offset = 32'h0; end
        4: begin cells = 6'd0;  offset = 32'h8000_0000; end
        5: begin cells = 6'd17; offset = 32'(pick_value() >>> 8); end
        6: begin cells = 6'd5;  offset = 32'h0; end
        default: begin cells = 6'($urandom_range(61, 1)); offset = $urandom; end
      endcase
      set_register(CfgCellsPerUnit, 32'(cells));
      set_register(CfgBaseOffset, offset);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      phase_start = sent_items;
      goal = sent_items + PhaseItems;
      while (sent_items < goal) begin
        // back-pressure: receiver holds off while requests keep coming
        if (p == 0 && hold_asks == 0 && sent_items - phase_start >= 40) hold_asks++;
        if (p == 0 && sent_items - phase_start == 150) wait_results();
        if ($urandom_range(99) < 45)
          put_request(CmdWrite, idx_t'($urandom), idx_t'($urandom), pick_value(),
                      pick_coord(), pick_coord(), 1'($urandom), 1'b0, '0);
        else
          eval_point(pick_coord(), pick_coord(), 1'($urandom), 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
